@@ src/hslb_pkg.sv @@
// Package with the shared types and constants of the HSL to RGB brightness unit.
`default_nettype none
package hslb_pkg;

   localparam int HUE_W = 16;
   localparam int PCT_W = 11;
   localparam int CH_W  = 8;
   localparam int REM_W = 12;
   localparam int CN_W  = 22;
   localparam int LB_W  = 23;
   localparam int P_W   = 34;
   localparam int V_W   = 36;
   localparam int N_W   = 45;
   localparam int T_W   = 23;
   localparam int M_W   = 46;

   localparam logic [HUE_W-1:0] HUE_FULL   = 16'd23040;
   localparam logic [HUE_W-1:0] HUE_FULL2  = 16'd46080;
   localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd3840;
   localparam logic [PCT_W-1:0] PCT_FULL   = 11'd1600;

   localparam logic [V_W-1:0] Q_DEN       = 36'd19660800000;
   localparam int             T_SHIFT     = 22;
   localparam logic [T_W-1:0] RECIP       = 23'd7330078;
   localparam int             RECIP_SHIFT = 36;

   localparam int STAGES = 7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_BRIGHTNESS = 1'b0;
   localparam logic [CH_W-1:0] BRIGHT_RESET = 8'd255;

   typedef enum logic [2:0] {
      SEC_RY,
      SEC_YG,
      SEC_GC,
      SEC_CB,
      SEC_BM,
      SEC_MR
   } hslb_sector_type;

   typedef struct packed {
      logic t_en;
      logic q_en;
      logic out_en;
   } hslb_stage_en_type;

endpackage
`default_nettype wire

@@ src/hslb_chan.sv @@
// One color channel: rounding to 0..255 and brightness scaling over three stages.
`default_nettype none
module hslb_chan
   import hslb_pkg::*;
(
   input  wire logic              clock,
   input  wire hslb_stage_en_type en,
   input  wire logic [V_W-1:0]    v,
   input  wire logic [CH_W-1:0]   bright,
   output logic      [CH_W-1:0]   chan
);

   logic [N_W-1:0]    n;
   logic [T_W-1:0]    t_ff, t_in;
   logic [M_W-1:0]    prod;
   logic [CH_W-1:0]   q_ff, q_in;
   logic [2*CH_W-1:0] scaled;
   logic [2*CH_W:0]   div_sum;
   logic [CH_W-1:0]   out_ff, out_in;

   always_comb begin
      n       = (N_W'(v) << 9) - (N_W'(v) << 1) + N_W'(Q_DEN);
      t_in    = n[N_W-1:T_SHIFT];
      prod    = M_W'(t_ff) * M_W'(RECIP);
      q_in    = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
      scaled  = (2*CH_W)'(q_ff) * (2*CH_W)'(bright);
      div_sum = (2*CH_W+1)'(scaled) + (2*CH_W+1)'(scaled[2*CH_W-1:CH_W])
              + (2*CH_W+1)'(1);
      out_in  = div_sum[2*CH_W-1:CH_W];
   end

   always_ff @(posedge clock) begin
      if (en.t_en) begin
         t_ff <= t_in;
      end
      if (en.q_en) begin
         q_ff <= q_in;
      end
      if (en.out_en) begin
         out_ff <= out_in;
      end
   end

   assign chan = out_ff;

endmodule
`default_nettype wire

@@ src/hsl_to_rgb_with_brightness_unit.sv @@
// Top level of the HSL to RGB converter with a global brightness register.
//
//   channel  ports                         direction  payload
//   req      req_valid, req_stall          in         hue, saturation, lightness
//   rsp      rsp_valid, rsp_stall          out        red, green, blue
//   csr      csr_psel .. csr_pready        in/out     brightness at byte 0
//
// One item enters per clock while req_stall is low; rsp_valid shows it after the last stage.
// There are seven register stages; the multipliers feed stages two, three, six and seven.
// Reset clears all stage valid bits and sets brightness to 255.
// A stall on rsp holds the pipeline; empty stages keep filling until it is full.
`default_nettype none
module hsl_to_rgb_with_brightness_unit
   import hslb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [HUE_W-1:0]      req_hue,
   input  wire logic [PCT_W-1:0]      req_saturation,
   input  wire logic [PCT_W-1:0]      req_lightness,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [CH_W-1:0]       rsp_red,
   output logic      [CH_W-1:0]       rsp_green,
   output logic      [CH_W-1:0]       rsp_blue,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [CH_W-1:0]       bright_ff, bright_in;
   logic                  csr_wr;
   logic [CSR_ADDR_W-3:0] csr_idx;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] rdy;

   logic [HUE_W-1:0]  hh;
   logic [REM_W-1:0]  rem;
   logic [REM_W-1:0]  w1;
   logic [PCT_W:0]    l2;
   logic [PCT_W-1:0]  s_cl, l_cl, a1;
   hslb_sector_type   sec1;

   logic [PCT_W-1:0]  s1_s_ff, s1_l_ff, s1_a_ff;
   logic [REM_W-1:0]  s1_w_ff;
   hslb_sector_type   s1_sec_ff;

   logic [CN_W-1:0]   s2_cn_ff, s2_cn_in;
   logic [PCT_W-1:0]  s2_l_ff;
   logic [REM_W-1:0]  s2_w_ff;
   hslb_sector_type   s2_sec_ff;

   logic [CN_W-1:0]   s3_cn_ff;
   logic [LB_W-1:0]   s3_base_ff, s3_base_in;
   logic [P_W-1:0]    s3_p_ff, s3_p_in;
   hslb_sector_type   s3_sec_ff;

   logic [LB_W-1:0]   sc, sm;
   logic [V_W-1:0]    vc, vm, vx;
   logic [V_W-1:0]    v_in [3];
   logic [V_W-1:0]    v_ff [3];

   hslb_stage_en_type chan_en;

   // Configuration port.
   always_comb begin
      csr_idx   = csr_paddr[CSR_ADDR_W-1:2];
      csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
      bright_in = bright_ff;
      if (csr_wr && csr_idx == REG_BRIGHTNESS) begin
         bright_in = csr_pwdata[CH_W-1:0];
      end
      if (csr_idx == REG_BRIGHTNESS) begin
         csr_prdata = CSR_DATA_W'(bright_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;

   // Pipeline flow control.
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // Stage one: hue reduction, sector, clamping.
   always_comb begin
      if (req_hue >= HUE_FULL2) begin
         hh = req_hue - HUE_FULL2;
      end else if (req_hue >= HUE_FULL) begin
         hh = req_hue - HUE_FULL;
      end else begin
         hh = req_hue;
      end
      priority if (hh < HUE_SECTOR) begin
         sec1 = SEC_RY;
         rem  = REM_W'(hh);
      end else if (hh < 16'(2) * HUE_SECTOR) begin
         sec1 = SEC_YG;
         rem  = REM_W'(hh - HUE_SECTOR);
      end else if (hh < 16'(3) * HUE_SECTOR) begin
         sec1 = SEC_GC;
         rem  = REM_W'(hh - 16'(2) * HUE_SECTOR);
      end else if (hh < 16'(4) * HUE_SECTOR) begin
         sec1 = SEC_CB;
         rem  = REM_W'(hh - 16'(3) * HUE_SECTOR);
      end else if (hh < 16'(5) * HUE_SECTOR) begin
         sec1 = SEC_BM;
         rem  = REM_W'(hh - 16'(4) * HUE_SECTOR);
      end else begin
         sec1 = SEC_MR;
         rem  = REM_W'(hh - 16'(5) * HUE_SECTOR);
      end
      if (sec1 == SEC_RY || sec1 == SEC_GC || sec1 == SEC_BM) begin
         w1 = rem;
      end else begin
         w1 = REM_W'(HUE_SECTOR) - rem;
      end
      s_cl = (req_saturation > PCT_FULL) ? PCT_FULL : req_saturation;
      l_cl = (req_lightness > PCT_FULL) ? PCT_FULL : req_lightness;
      l2   = {l_cl, 1'b0};
      if (l2 >= (PCT_W+1)'(PCT_FULL)) begin
         a1 = PCT_W'({PCT_FULL, 1'b0} - l2);
      end else begin
         a1 = PCT_W'(l2);
      end
   end

   // Stages two to four: chroma, secondary term, offset and sector mapping.
   always_comb begin
      s2_cn_in   = CN_W'(s1_a_ff) * CN_W'(s1_s_ff);
      s3_base_in = LB_W'(s2_l_ff) * LB_W'(3200);
      s3_p_in    = P_W'(s2_cn_ff) * P_W'(s2_w_ff);
      sc = s3_base_ff + LB_W'(s3_cn_ff);
      sm = s3_base_ff - LB_W'(s3_cn_ff);
      vc = (V_W'(sc) << 12) - (V_W'(sc) << 8);
      vm = (V_W'(sm) << 12) - (V_W'(sm) << 8);
      vx = (V_W'(s3_p_ff) << 1) + vm;
      unique case (s3_sec_ff)
         SEC_RY: begin
            v_in[0] = vc; v_in[1] = vx; v_in[2] = vm;
         end
         SEC_YG: begin
            v_in[0] = vx; v_in[1] = vc; v_in[2] = vm;
         end
         SEC_GC: begin
            v_in[0] = vm; v_in[1] = vc; v_in[2] = vx;
         end
         SEC_CB: begin
            v_in[0] = vm; v_in[1] = vx; v_in[2] = vc;
         end
         SEC_BM: begin
            v_in[0] = vx; v_in[1] = vm; v_in[2] = vc;
         end
         default: begin
            v_in[0] = vc; v_in[1] = vm; v_in[2] = vx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
         vld_ff    <= '0;
      end else begin
         bright_ff <= bright_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_s_ff   <= s_cl;
         s1_l_ff   <= l_cl;
         s1_a_ff   <= a1;
         s1_w_ff   <= w1;
         s1_sec_ff <= sec1;
      end
      if (rdy[1]) begin
         s2_cn_ff  <= s2_cn_in;
         s2_l_ff   <= s1_l_ff;
         s2_w_ff   <= s1_w_ff;
         s2_sec_ff <= s1_sec_ff;
      end
      if (rdy[2]) begin
         s3_cn_ff   <= s2_cn_ff;
         s3_base_ff <= s3_base_in;
         s3_p_ff    <= s3_p_in;
         s3_sec_ff  <= s2_sec_ff;
      end
      if (rdy[3]) begin
         v_ff <= v_in;
      end
   end

   assign chan_en = '{t_en: rdy[4], q_en: rdy[5], out_en: rdy[6]};

   hslb_chan u_red (
      .clock  (clock),
      .en     (chan_en),
      .v      (v_ff[0]),
      .bright (bright_ff),
      .chan   (rsp_red)
   );

   hslb_chan u_green (
      .clock  (clock),
      .en     (chan_en),
      .v      (v_ff[1]),
      .bright (bright_ff),
      .chan   (rsp_green)
   );

   hslb_chan u_blue (
      .clock  (clock),
      .en     (chan_en),
      .v      (v_ff[2]),
      .bright (bright_ff),
      .chan   (rsp_blue)
   );

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("input stalled while a pipeline stage was empty");

   a_held_item_stays: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !rdy[0]) |=> vld_ff[0])
      else $error("first stage dropped an item it was holding");

   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-2] && rdy[STAGES-1]) |=> vld_ff[STAGES-1])
      else $error("item lost on the way into the output stage");

   a_bright_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_BRIGHTNESS) |=> bright_ff == $past(csr_pwdata[CH_W-1:0]))
      else $error("brightness write not taken");

endmodule
`default_nettype wire

@@ tb/sv/hsl_to_rgb_with_brightness_unit_tb.sv @@
// Self-checking testbench for the HSL to RGB converter with brightness register.
module hsl_to_rgb_with_brightness_unit_tb;
   import hslb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] ADDR_BRIGHTNESS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE      = 3'd4;

   localparam longint unsigned HUE_PERIOD  = 23040;
   localparam longint unsigned SECTOR_SPAN = 3840;
   localparam longint unsigned PCT_MAX     = 1600;
   localparam longint unsigned FRAC_DEN    = 2 * SECTOR_SPAN * PCT_MAX * PCT_MAX;

   localparam int PIPE_DEPTH     = 7;
   localparam int DRAIN_CYCLES   = PIPE_DEPTH + 5;
   localparam int STALL_LIMIT    = 2000;
   localparam int PHASE_COUNT    = 6;
   localparam int PIXELS_PER_PHASE = 305;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] lightness;
   } pixel_hsl_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_rgb_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [HUE_W-1:0]      req_hue = '0;
   logic [PCT_W-1:0]      req_saturation = '0;
   logic [PCT_W-1:0]      req_lightness = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_red;
   logic [CH_W-1:0]       rsp_green;
   logic [CH_W-1:0]       rsp_blue;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pixel_hsl_type pending_pixels[$];
   pixel_rgb_type expected_rgb[$];
   logic [CH_W-1:0] brightness_now = BRIGHT_RESET;
   logic req_fire = 1'b0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int pixels_in = 0;
   int pixels_out = 0;
   int quiet_cycles = 0;

   hsl_to_rgb_with_brightness_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic pixel_rgb_type hsl_expected(input pixel_hsl_type px,
                                                  input logic [CH_W-1:0] gain);
      longint unsigned hh, s, l, dl, cn, hm, hue_dist, cq, xq, mq, chan;
      longint unsigned lvl[3];
      logic [CH_W-1:0] scaled[3];
      hslb_sector_type sec;
      pixel_rgb_type res;
      int k;
      hh = px.hue % HUE_PERIOD;
      s = (px.saturation > PCT_MAX) ? PCT_MAX : px.saturation;
      l = (px.lightness > PCT_MAX) ? PCT_MAX : px.lightness;
      dl = (2 * l >= PCT_MAX) ? (2 * l - PCT_MAX) : (PCT_MAX - 2 * l);
      cn = (PCT_MAX - dl) * s;
      hm = hh % (2 * SECTOR_SPAN);
      hue_dist = (hm >= SECTOR_SPAN) ? (hm - SECTOR_SPAN) : (SECTOR_SPAN - hm);
      cq = cn * 2 * SECTOR_SPAN;
      xq = cn * (SECTOR_SPAN - hue_dist) * 2;
      mq = l * PCT_MAX * 2 * SECTOR_SPAN - cn * SECTOR_SPAN;
      sec = hslb_sector_type'(hh / SECTOR_SPAN);
      case (sec)
         SEC_RY: begin lvl[0] = cq; lvl[1] = xq; lvl[2] = 0;  end
         SEC_YG: begin lvl[0] = xq; lvl[1] = cq; lvl[2] = 0;  end
         SEC_GC: begin lvl[0] = 0;  lvl[1] = cq; lvl[2] = xq; end
         SEC_CB: begin lvl[0] = 0;  lvl[1] = xq; lvl[2] = cq; end
         SEC_BM: begin lvl[0] = xq; lvl[1] = 0;  lvl[2] = cq; end
         default: begin lvl[0] = cq; lvl[1] = 0;  lvl[2] = xq; end
      endcase
      for (k = 0; k < 3; k++) begin
         chan = ((lvl[k] + mq) * 510 + FRAC_DEN) / (2 * FRAC_DEN);
         if (chan > 255) begin
            chan = 255;
         end
         chan = chan * gain / 255;
         scaled[k] = chan[CH_W-1:0];
      end
      res.red = scaled[0];
      res.green = scaled[1];
      res.blue = scaled[2];
      return res;
   endfunction

   function automatic pixel_hsl_type random_pixel();
      pixel_hsl_type px;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         px.hue = HUE_W'($urandom_range(0, 65535));
      end else if (pick < 8) begin
         px.hue = 16'($urandom_range(0, 17) * 3840 + $urandom_range(0, 6) - 3);
      end else if (pick == 8) begin
         px.hue = HUE_W'($urandom_range(0, 23039));
      end else begin
         px.hue = HUE_W'($urandom_range(23040, 65535));
      end
      pick = $urandom_range(0, 9);
      case (pick)
         6: px.saturation = 11'd1600;
         7: px.saturation = 11'd0;
         8: px.saturation = PCT_W'($urandom_range(1601, 2047));
         9: px.saturation = PCT_W'($urandom_range(0, 1600));
         default: px.saturation = PCT_W'($urandom_range(0, 2047));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
         5: px.lightness = PCT_W'($urandom_range(797, 803));
         6: px.lightness = 11'd1600;
         7: px.lightness = PCT_W'($urandom_range(0, 3));
         8: px.lightness = PCT_W'($urandom_range(1601, 2047));
         9: px.lightness = PCT_W'($urandom_range(0, 1600));
         default: px.lightness = PCT_W'($urandom_range(0, 2047));
      endcase
      return px;
   endfunction

   task automatic add_pixel(input int h, input int s, input int l);
      pixel_hsl_type px;
      px.hue = h[HUE_W-1:0];
      px.saturation = s[PCT_W-1:0];
      px.lightness = l[PCT_W-1:0];
      pending_pixels.push_back(px);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr && addr == ADDR_BRIGHTNESS) begin
         brightness_now = data[CH_W-1:0];
      end
      if (!wr && csr_prdata !== {{(CSR_DATA_W-CH_W){1'b0}}, brightness_now}) begin
         $error("brightness readback mismatch: expected %0d, actual %0d",
                brightness_now, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_rgb.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      pixel_hsl_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            nxt = pending_pixels.pop_front();
            req_hue <= nxt.hue;
            req_saturation <= nxt.saturation;
            req_lightness <= nxt.lightness;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      pixel_hsl_type px;
      pixel_rgb_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            px.hue = req_hue;
            px.saturation = req_saturation;
            px.lightness = req_lightness;
            expected_rgb.push_back(hsl_expected(px, brightness_now));
            pixels_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            pixels_out++;
            if (expected_rgb.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d",
                      rsp_red, rsp_green, rsp_blue);
               error_count++;
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red mismatch: expected %0d, actual %0d", want.red, rsp_red);
                  error_count++;
               end
               if (rsp_green !== want.green) begin
                  $error("green mismatch: expected %0d, actual %0d", want.green, rsp_green);
                  error_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue mismatch: expected %0d, actual %0d", want.blue, rsp_blue);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
         $display("FAIL hsl_to_rgb_with_brightness_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      int n;
      logic [CH_W-1:0] gain;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, ADDR_BRIGHTNESS, '0);

      add_pixel(0, 1600, 800);
      add_pixel(3839, 1600, 800);
      add_pixel(3840, 1600, 800);
      add_pixel(7680, 1600, 800);
      add_pixel(11520, 1600, 800);
      add_pixel(15360, 1600, 800);
      add_pixel(19200, 1600, 800);
      add_pixel(23039, 1600, 800);
      add_pixel(23040, 1600, 800);
      add_pixel(65535, 2047, 2047);
      add_pixel(46080, 1601, 799);
      add_pixel(0, 0, 0);
      add_pixel(0, 0, 1600);
      add_pixel(0, 2047, 0);
      add_pixel(1920, 1600, 1);
      add_pixel(5760, 1, 1599);
      add_pixel(9600, 800, 400);
      add_pixel(13440, 2047, 1200);
      add_pixel(17280, 1600, 2047);
      add_pixel(65535, 0, 1024);
      add_pixel(32768, 1024, 1024);
      add_pixel(1, 1, 1);
      add_pixel(21120, 1234, 801);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: gain = 8'd0;
               2: gain = 8'd1;
               3: gain = 8'd255;
               4: gain = 8'd127;
               default: gain = CH_W'($urandom_range(2, 254));
            endcase
            csr_access(1'b1, ADDR_SPARE, $urandom);
            csr_access(1'b1, ADDR_BRIGHTNESS, {24'($urandom), gain});
            csr_access(1'b0, ADDR_BRIGHTNESS, '0);
         end
         case (phase % 4)
            0: begin req_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct <= 52; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct <= 0;  rsp_stall_pct <= 52; end
            default: begin req_idle_pct <= 29; rsp_stall_pct <= 29; end
         endcase
         @(posedge clock);
         for (n = 0; n < PIXELS_PER_PHASE; n++) begin
            pending_pixels.push_back(random_pixel());
         end
      end
      wait_drained();

      if (expected_rgb.size() != 0) begin
         $error("%0d expected results never arrived", expected_rgb.size());
         error_count++;
      end
      $display("Sent %0d pixels and checked %0d results across %0d brightness settings,",
               pixels_in, pixels_out, PHASE_COUNT);
      $display("with free-running, idle-sender, stalled-receiver and mixed pacing.");
      if (error_count == 0) begin
         $display("PASS hsl_to_rgb_with_brightness_unit");
      end else begin
         $display("FAIL hsl_to_rgb_with_brightness_unit");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/hslb_pkg.sv
src/hslb_chan.sv
src/hsl_to_rgb_with_brightness_unit.sv
tb/sv/hsl_to_rgb_with_brightness_unit_tb.sv
